@@ hw/rtl/bcs_pkg.sv @@
// ----------------------------------------------------------------------------
// bcs_pkg
// Types and character codes shared by the block comment stripper.
// ----------------------------------------------------------------------------
package bcs_pkg;

  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;

  // Most results one input item can cause
  localparam int unsigned MaxResults = 3;
  // Output queue depth and its index / count widths
  localparam int unsigned QDepth = 4;
  localparam int unsigned QIdxW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [2:0] {
    MODE_NORMAL  = 3'd0,
    MODE_SLASH   = 3'd1,
    MODE_OPEN0   = 3'd2,
    MODE_OPEN1   = 3'd3,
    MODE_COMMENT = 3'd4,
    MODE_QUOTE   = 3'd5,
    MODE_ESC     = 3'd6
  } scan_mode_e;

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       stream_end;
  } result_t;

endpackage

@@ hw/rtl/block_comment_stripper.sv @@
// ----------------------------------------------------------------------------
// block_comment_stripper
// Copies a byte stream through and deletes slash-star block comments,
// leaving quoted literals (with backslash escapes) untouched.
//
// Input channel: in_valid_i / in_stall_o carry in_byte_i and in_last_i;
// in_last_i marks the final byte of a stream. Output channel:
// out_valid_o / out_stall_i carry out_byte_o, byte_valid_o and
// stream_end_o. An item is taken at an edge where valid is high and stall
// is low. One input item gives zero to three results; the last item of a
// stream always gives at least one, and a bare end marker (byte_valid_o
// low) stands in when nothing else is left to send.
// Results of an item are written to a registered queue and leave it in
// order. Throughput: one input item per cycle as long as the output keeps
// up; the four-entry result queue stalls the input while it holds more
// than one result, so items that expand to several bytes drain at one
// result per cycle. A stalled output holds its result and backs up into
// the queue. Reset empties the queue and returns the scanner to plain
// text; after the last item of a stream the scanner starts over as well.
// ----------------------------------------------------------------------------
module block_comment_stripper (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       stream_end_o
);
  import bcs_pkg::*;

  scan_mode_e mode_q, mode_d;
  logic [7:0] held_q, held_d;
  logic       star_q, star_d;
  logic       dq_q, dq_d;

  result_t    slot [MaxResults];
  logic [1:0] n_res;

  result_t          fifo_q [QDepth];
  logic [QIdxW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  logic in_acc, out_acc;
  logic [7:0] qc;

  assign in_stall_o = (cnt_q > QCntW'(QDepth - MaxResults));
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_valid_o = (cnt_q != '0);
  assign out_acc    = out_valid_o && !out_stall_i;

  assign out_byte_o   = fifo_q[rd_ptr_q].data;
  assign byte_valid_o = fifo_q[rd_ptr_q].byte_valid;
  assign stream_end_o = fifo_q[rd_ptr_q].stream_end;

  assign qc = dq_q ? ChDquote : ChSquote;

  // Scanner: next state and the results of the item at the input
  always_comb begin
    logic do_plain;
    mode_d   = mode_q;
    held_d   = held_q;
    star_d   = star_q;
    dq_d     = dq_q;
    n_res    = 2'd0;
    do_plain = 1'b0;
    for (int i = 0; i < MaxResults; i++) begin
      slot[i] = '{data: 8'h00, byte_valid: 1'b1, stream_end: 1'b0};
    end

    case (mode_q)
      MODE_SLASH: begin
        if (in_byte_i == ChStar) begin
          if (in_last_i) begin
            slot[0].data = ChSlash;
            slot[1].data = ChStar;
            n_res = 2'd2;
          end else begin
            mode_d = MODE_OPEN0;
          end
        end else begin
          slot[0].data = ChSlash;
          n_res    = 2'd1;
          do_plain = 1'b1;
        end
      end
      MODE_OPEN0: begin
        if (in_last_i) begin
          slot[0].data = ChSlash;
          slot[1].data = ChStar;
          slot[2].data = in_byte_i;
          n_res = 2'd3;
        end else begin
          held_d = in_byte_i;
          mode_d = MODE_OPEN1;
        end
      end
      MODE_OPEN1: begin
        if (held_q == ChSlash) begin
          do_plain = 1'b1;
        end else if (held_q == ChStar && in_byte_i == ChSlash) begin
          mode_d = MODE_NORMAL;
        end else begin
          mode_d = MODE_COMMENT;
          star_d = (in_byte_i == ChStar);
        end
        held_d = 8'h00;
      end
      MODE_COMMENT: begin
        if (star_q && in_byte_i == ChSlash) begin
          mode_d = MODE_NORMAL;
          star_d = 1'b0;
        end else begin
          star_d = (in_byte_i == ChStar);
        end
      end
      MODE_QUOTE: begin
        slot[0].data = in_byte_i;
        n_res = 2'd1;
        if (in_byte_i == ChBslash) begin
          mode_d = MODE_ESC;
        end else if (in_byte_i == qc) begin
          mode_d = MODE_NORMAL;
        end
      end
      MODE_ESC: begin
        slot[0].data = in_byte_i;
        n_res  = 2'd1;
        mode_d = MODE_QUOTE;
      end
      default: begin
        do_plain = 1'b1;
      end
    endcase

    // Plain text byte: hold a slash, open a literal on a quote
    if (do_plain) begin
      if (in_byte_i == ChSlash && !in_last_i) begin
        mode_d = MODE_SLASH;
      end else begin
        slot[n_res].data = in_byte_i;
        n_res  = n_res + 2'd1;
        mode_d = MODE_NORMAL;
        if (!in_last_i && (in_byte_i == ChSquote || in_byte_i == ChDquote)) begin
          dq_d   = (in_byte_i == ChDquote);
          mode_d = MODE_QUOTE;
        end
      end
    end

    // End of stream: flag the final result and start over
    if (in_last_i) begin
      if (n_res == 2'd0) begin
        slot[0] = '{data: 8'h00, byte_valid: 1'b0, stream_end: 1'b1};
        n_res   = 2'd1;
      end else begin
        slot[n_res - 2'd1].stream_end = 1'b1;
      end
      mode_d = MODE_NORMAL;
      held_d = 8'h00;
      star_d = 1'b0;
      dq_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
      held_q <= 8'h00;
      star_q <= 1'b0;
      dq_q   <= 1'b0;
    end else if (in_acc) begin
      mode_q <= mode_d;
      held_q <= held_d;
      star_q <= star_d;
      dq_q   <= dq_d;
    end
  end

  // Result queue: push up to three results, pop one per cycle unless the output stalls
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < MaxResults; i++) begin
        if (2'(i) < n_res) begin
          fifo_q[wr_ptr_q + QIdxW'(i)] <= slot[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (in_acc) begin
        wr_ptr_q <= wr_ptr_q + QIdxW'(n_res);
      end
      if (out_acc) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + (in_acc ? QCntW'(n_res) : '0) - QCntW'(out_acc);
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("result queue count out of range");

  a_room_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> cnt_q <= QCntW'(QDepth - MaxResults))
    else $error("item accepted without room for its results");

  a_bare_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> stream_end_o)
    else $error("bare result without end flag");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_last_i |=> mode_q == MODE_NORMAL && !star_q)
    else $error("scanner not restarted after stream end");
`endif

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Testbench for block_comment_stripper. It sends byte streams made of plain
// text, block comments and quoted literals, both whole and cut short. A
// cycle-free model of the scanner predicts the kept bytes and end markers,
// and each result taken from the output is checked against the oldest
// prediction. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bcs_pkg::*;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i = 8'h00;
  logic       in_last_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       byte_valid_o;
  logic       stream_end_o;

  block_comment_stripper dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .byte_valid_o(byte_valid_o),
    .stream_end_o(stream_end_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  int unsigned src_idle_pct  = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned err_cnt       = 0;
  int unsigned sent_cnt      = 0;

  // Scanner state of the predictor
  scan_mode_e scan_mode;
  logic [7:0] held_byte;
  logic       prev_star;
  logic       quote_dq;

  result_t step_q[$];  // results of the item being predicted
  result_t kept_q[$];  // results still due from the block
  logic [7:0] text_q[$];

  function automatic void clear_scanner();
    scan_mode = MODE_NORMAL;
    held_byte = 8'h00;
    prev_star = 1'b0;
    quote_dq  = 1'b0;
  endfunction

  function automatic void emit_byte(logic [7:0] b);
    step_q.push_back('{b, 1'b1, 1'b0});
  endfunction

  function automatic void plain_in(logic [7:0] b, logic last);
    if (b == ChSlash && !last) begin
      scan_mode = MODE_SLASH;
    end else begin
      emit_byte(b);
      scan_mode = MODE_NORMAL;
      if (!last && (b == ChSquote || b == ChDquote)) begin
        quote_dq  = (b == ChDquote);
        scan_mode = MODE_QUOTE;
      end
    end
  endfunction

  function automatic void strip_byte(logic [7:0] b, logic last);
    result_t r;
    step_q = {};
    case (scan_mode)
      MODE_SLASH: begin
        if (b == ChStar) begin
          if (last) begin
            emit_byte(ChSlash);
            emit_byte(ChStar);
          end else begin
            scan_mode = MODE_OPEN0;
          end
        end else begin
          emit_byte(ChSlash);
          plain_in(b, last);
        end
      end
      MODE_OPEN0: begin
        if (last) begin
          emit_byte(ChSlash);
          emit_byte(ChStar);
          emit_byte(b);
        end else begin
          held_byte = b;
          scan_mode = MODE_OPEN1;
        end
      end
      MODE_OPEN1: begin
        // the opener's star may close the comment on its own
        if (held_byte == ChSlash) begin
          plain_in(b, last);
        end else if (held_byte == ChStar && b == ChSlash) begin
          scan_mode = MODE_NORMAL;
        end else begin
          scan_mode = MODE_COMMENT;
          prev_star = (b == ChStar);
        end
        held_byte = 8'h00;
      end
      MODE_COMMENT: begin
        if (prev_star && b == ChSlash) begin
          scan_mode = MODE_NORMAL;
          prev_star = 1'b0;
        end else begin
          prev_star = (b == ChStar);
        end
      end
      MODE_QUOTE: begin
        emit_byte(b);
        if (b == ChBslash) begin
          scan_mode = MODE_ESC;
        end else if (b == (quote_dq ? ChDquote : ChSquote)) begin
          scan_mode = MODE_NORMAL;
        end
      end
      MODE_ESC: begin
        emit_byte(b);
        scan_mode = MODE_QUOTE;
      end
      default: plain_in(b, last);
    endcase
    if (last) begin
      if (step_q.size() == 0) begin
        step_q.push_back('{8'h00, 1'b0, 1'b1});
      end else begin
        r = step_q.pop_back();
        r.stream_end = 1'b1;
        step_q.push_back(r);
      end
      clear_scanner();
    end
    foreach (step_q[i]) kept_q.push_back(step_q[i]);
  endfunction

  // Call at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    in_last_i  <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    strip_byte(b, last);
    sent_cnt++;
    @(negedge clk_i);
  endtask

  task automatic send_str(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  // Lean toward the characters the scanner reacts to
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0: return ChSlash;
      1: return ChStar;
      2: return ChSquote;
      3: return ChDquote;
      4: return ChBslash;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void build_text();
    logic [7:0] q;
    logic [7:0] c;
    text_q = {};
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          repeat ($urandom_range(1, 4)) text_q.push_back(pick_char());
        end
        2, 3, 4: begin
          text_q.push_back(ChSlash);
          text_q.push_back(ChStar);
          repeat ($urandom_range(0, 5)) text_q.push_back(pick_char());
          // leave some comments open
          if ($urandom_range(0, 7) != 0) begin
            text_q.push_back(ChStar);
            text_q.push_back(ChSlash);
          end
        end
        5, 6: begin
          q = $urandom_range(0, 1) ? ChDquote : ChSquote;
          text_q.push_back(q);
          repeat ($urandom_range(0, 5)) begin
            c = pick_char();
            text_q.push_back(c);
            if (c == ChBslash) text_q.push_back(pick_char());
          end
          if ($urandom_range(0, 7) != 0) text_q.push_back(q);
        end
        7: begin
          text_q.push_back(ChSlash);
          text_q.push_back(ChStar);
          text_q.push_back(ChSlash);
        end
        default: begin
          repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(0, 255)));
        end
      endcase
    end
  endfunction

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < sink_stall_pct);
  end

  always @(posedge clk_i) begin : check_kept
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (kept_q.size() == 0) begin
        err_cnt++;
        $display("%0t: result with none due: byte=%h byte_valid=%b stream_end=%b",
                 $time, out_byte_o, byte_valid_o, stream_end_o);
      end else begin
        want = kept_q.pop_front();
        if (want !== {out_byte_o, byte_valid_o, stream_end_o}) begin
          err_cnt++;
          $display("%0t: expected byte=%h byte_valid=%b stream_end=%b, got %h %b %b",
                   $time, want.data, want.byte_valid, want.stream_end,
                   out_byte_o, byte_valid_o, stream_end_o);
        end
      end
    end
  end

  task automatic test_plain_extremes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_short_openers();
    send_str("/");
    send_str("/*");
    send_byte(ChSlash, 1'b0);
    send_byte(ChStar, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_comment_ends();
    send_str("/*/'");   // self-closing comment, then a quote as the last byte
    send_str("/**/");   // closed on the last byte: bare end marker
    send_str("/*xy");   // still open at the end: dropped
  endtask

  task automatic test_literals();
    send_str("\"\\\"\"");
  endtask

  task automatic test_random_streams(int unsigned n_items);
    int unsigned stop_at;
    stop_at = sent_cnt + n_items;
    while (sent_cnt < stop_at) begin
      build_text();
      send_text();
    end
  endtask

  initial begin
    clear_scanner();
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    src_idle_pct   = 16;
    sink_stall_pct = 71;
    test_plain_extremes();
    test_short_openers();
    test_comment_ends();
    test_literals();
    test_random_streams(134);

    src_idle_pct   = 71;
    sink_stall_pct = 16;
    test_random_streams(133);

    src_idle_pct   = 0;
    sink_stall_pct = 0;
    test_random_streams(133);
    in_valid_i <= 1'b0;

    while (kept_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0 && kept_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
